FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define TRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen at a rising clock edge outside reset.
`define TRS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `TRS_ASSERT(label, clk, rst, !(expr), msg)

`endif

FILE: hw/rtl/trs_pkg.sv
// Shared widths, codes and types of the ternary rejection sampler.
package trs_pkg;

   localparam int BYTE_W  = 8;
   localparam int ACC_W   = 22;
   localparam int HELD_W  = 5;
   localparam int CNT_W   = 11;
   localparam int MODE_W  = 2;
   localparam int COEF_W  = 2;
   localparam int GROUP_W = 12;
   localparam int LANES   = 3;

   localparam int COUNT_MAX_DEFAULT = 1024;
   localparam int COUNT_RESET       = 256;

   // Mode register codes; the unused code behaves as the nibble mode.
   localparam logic [MODE_W-1:0] MODE_DEC3   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEC4   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NIBBLE = 2'd2;

   // Register indexes of the configuration port.
   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   // Ternary coefficient codes.
   localparam logic signed [COEF_W-1:0] COEF_ZERO = 2'sb00;
   localparam logic signed [COEF_W-1:0] COEF_POS  = 2'sb01;
   localparam logic signed [COEF_W-1:0] COEF_NEG  = 2'sb11;

   typedef struct packed {
      logic             valid;
      logic [LANES-1:0] nonzero;
   } group_type;

endpackage

FILE: hw/rtl/ternary_rejection_sampler.sv
// Ternary rejection sampler top level: bit accumulator, group issue and result buffer.
//
// Random bytes enter a 22-bit accumulator least significant bit first. When 13 bits
// (decimal modes) or 15 bits (nibble mode) are held, one group is decoded in the same
// cycle the byte is taken, and its zero to three coefficients are loaded into a
// three-entry result buffer that drains one coefficient per cycle on the response
// channel while rsp_ready is high. No byte is taken while more than one coefficient
// of the previous byte is pending; the next request is accepted in the cycle the
// last coefficient of the previous one is handed over. Configuration writes take
// effect at the next clock edge and are meant for idle periods. No clearing pass
// follows reset.
module ternary_rejection_sampler #(
   parameter int COUNT_MAX = trs_pkg::COUNT_MAX_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [trs_pkg::BYTE_W-1:0]         req_random_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [trs_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic                               rsp_run_end,
   output logic                               rsp_poly_end,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [trs_pkg::CNT_W-1:0]          csr_write_data
);

   localparam int CNT_W  = trs_pkg::CNT_W;
   localparam int ACC_W  = trs_pkg::ACC_W;
   localparam int HELD_W = trs_pkg::HELD_W;
   localparam int LANES  = trs_pkg::LANES;

   localparam logic [CNT_W-1:0] COUNT_CLAMP =
      (COUNT_MAX >= (2 ** CNT_W)) ? {CNT_W{1'b1}} : CNT_W'(COUNT_MAX);
   localparam logic [CNT_W-1:0] COUNT_AT_RESET =
      (trs_pkg::COUNT_RESET > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(trs_pkg::COUNT_RESET);

   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [HELD_W-1:0]          held_ff, held_in;
   logic [CNT_W-1:0]           done_ff, done_in;
   logic [trs_pkg::MODE_W-1:0] mode_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [1:0]                 fill_ff, fill_in;
   logic signed [trs_pkg::COEF_W-1:0] coef_ff [LANES];
   logic [LANES-1:0]           poly_ff;

   logic [ACC_W-1:0]           acc_sum;
   logic [ACC_W-1:0]           acc_rest;
   logic [HELD_W-1:0]          held_sum;
   logic [HELD_W-1:0]          held_rest;
   logic                       nibble;
   logic                       take;
   trs_pkg::group_type         group;

   logic signed [trs_pkg::COEF_W-1:0] coef_new [LANES];
   logic [LANES-1:0]           poly_new;
   logic [1:0]                 n_new;
   logic [1:0]                 used;
   logic [CNT_W-1:0]           tally;
   logic                       stop;

   logic                       req_accept;
   logic                       rsp_pop;

   trs_decode u_decode (
      .mode       (mode_ff),
      .group_bits (acc_sum[trs_pkg::GROUP_W-1:0]),
      .group      (group)
   );

   assign req_ready  = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = fill_ff != 2'd0;
   assign rsp_pop    = rsp_valid && rsp_ready;

   assign rsp_coefficient = coef_ff[0];
   assign rsp_poly_end    = poly_ff[0];
   assign rsp_run_end     = fill_ff == 2'd1;

   // A zero count acts as one, and a count above the limit acts as the limit.
   always_comb begin
      if (csr_write_data == '0) begin
         count_in = CNT_W'(1);
      end else if (csr_write_data > COUNT_CLAMP) begin
         count_in = COUNT_CLAMP;
      end else begin
         count_in = csr_write_data;
      end
   end

   always_comb begin
      nibble    = mode_ff >= trs_pkg::MODE_NIBBLE;
      acc_sum   = acc_ff | (ACC_W'(req_random_byte) << held_ff[3:0]);
      held_sum  = held_ff + HELD_W'(trs_pkg::BYTE_W);
      take      = held_sum >= (nibble ? HELD_W'(15) : HELD_W'(13));
      acc_rest  = nibble ? (acc_sum >> 12) : (acc_sum >> 10);
      held_rest = held_sum - (nibble ? HELD_W'(12) : HELD_W'(10));
   end

   // Coefficients leave in digit order; each nonzero one takes the next bit above
   // the group as its sign, and the one that completes the count ends the group.
   always_comb begin
      n_new = 2'd0;
      used  = 2'd0;
      tally = done_ff;
      stop  = !(take && group.valid);
      for (int i = 0; i < LANES; i++) begin
         coef_new[i] = trs_pkg::COEF_ZERO;
         poly_new[i] = 1'b0;
         if (!stop) begin
            if (group.nonzero[i]) begin
               coef_new[i] = acc_rest[used] ? trs_pkg::COEF_POS : trs_pkg::COEF_NEG;
               used = used + 2'd1;
            end
            tally = tally + CNT_W'(1);
            if (tally >= count_ff) begin
               poly_new[i] = 1'b1;
               tally = '0;
               stop  = 1'b1;
            end
            n_new = n_new + 2'd1;
         end
      end
   end

   always_comb begin
      if (take) begin
         acc_in  = acc_rest >> used;
         held_in = held_rest - HELD_W'(used);
      end else begin
         acc_in  = acc_sum;
         held_in = held_sum;
      end
      done_in = tally;
      if (req_accept && (n_new != 2'd0)) begin
         fill_in = n_new;
      end else if (rsp_pop) begin
         fill_in = fill_ff - 2'd1;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         held_ff  <= '0;
         done_ff  <= '0;
         fill_ff  <= 2'd0;
         mode_ff  <= trs_pkg::MODE_DEC3;
         count_ff <= COUNT_AT_RESET;
      end else begin
         fill_ff <= fill_in;
         if (req_accept) begin
            acc_ff  <= acc_in;
            held_ff <= held_in;
            done_ff <= done_in;
         end
         if (csr_write_enable) begin
            if (csr_index == trs_pkg::REG_MODE) begin
               mode_ff <= csr_write_data[trs_pkg::MODE_W-1:0];
            end else begin
               count_ff <= count_in;
            end
         end
      end
   end

   // Result buffer: entry zero faces the response channel.
   always_ff @(posedge clock) begin
      if (req_accept && (n_new != 2'd0)) begin
         coef_ff <= coef_new;
         poly_ff <= poly_new;
      end else if (rsp_pop) begin
         for (int i = 0; i < LANES - 1; i++) begin
            coef_ff[i] <= coef_ff[i+1];
            poly_ff[i] <= poly_ff[i+1];
         end
      end
   end

endmodule

FILE: hw/rtl/trs_decode.sv
// Group decoder: splits one group into digits or nibbles and tests each one.
module trs_decode (
   input  logic [trs_pkg::MODE_W-1:0]  mode,
   input  logic [trs_pkg::GROUP_W-1:0] group_bits,
   output trs_pkg::group_type          group
);

   localparam logic [9:0]  DEC_LIMIT  = 10'd1000;
   localparam logic [17:0] RECIP_TEN  = 18'd205;
   localparam int          RECIP_SHIFT = 11;
   localparam logic [3:0]  NIBBLE_LIMIT = 4'd10;

   logic [9:0]  value;
   logic [17:0] prod_lo;
   logic [6:0]  tens;
   logic [14:0] prod_hi;
   logic [3:0]  hundreds;
   logic [9:0]  rem_lo;
   logic [6:0]  rem_hi;
   logic [3:0]  digit [trs_pkg::LANES];
   logic [3:0]  limit;

   // Division by ten is a multiply by 205 and a shift by eleven, exact for
   // every value below 1029.
   always_comb begin
      value    = group_bits[9:0];
      prod_lo  = {8'd0, value} * RECIP_TEN;
      tens     = prod_lo[RECIP_SHIFT +: 7];
      prod_hi  = {8'd0, tens} * RECIP_TEN[14:0];
      hundreds = prod_hi[RECIP_SHIFT +: 4];
      rem_lo   = value - {3'd0, tens} * 10'd10;
      rem_hi   = tens - {3'd0, hundreds} * 7'd10;
   end

   always_comb begin
      limit = (mode == trs_pkg::MODE_DEC4) ? 4'd4 : 4'd3;
      if (mode >= trs_pkg::MODE_NIBBLE) begin
         digit[0] = group_bits[3:0];
         digit[1] = group_bits[7:4];
         digit[2] = group_bits[11:8];
         group.valid = 1'b1;
         for (int i = 0; i < trs_pkg::LANES; i++) begin
            group.nonzero[i] = digit[i] < NIBBLE_LIMIT;
         end
      end else begin
         digit[0] = rem_lo[3:0];
         digit[1] = rem_hi[3:0];
         digit[2] = hundreds;
         group.valid = value < DEC_LIMIT;
         for (int i = 0; i < trs_pkg::LANES; i++) begin
            group.nonzero[i] = digit[i] < limit;
         end
      end
   end

endmodule

FILE: hw/rtl/trs_checker.sv
// Port-level assertion checker of the ternary rejection sampler and its bind.
`include "assert_macros.svh"

module trs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [trs_pkg::COEF_W-1:0] rsp_coefficient,
   input logic                              rsp_run_end,
   input logic                              rsp_poly_end
);

   // A stalled response keeps its whole payload.
   `TRS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coefficient) && $stable(rsp_run_end) && $stable(rsp_poly_end), "stalled response changed")

   // While more than one coefficient of a request is pending, no new request is taken.
   `TRS_ASSERT_NEVER(a_no_take_mid_run, clock, reset, rsp_valid && !rsp_run_end && req_ready, "request taken in the middle of a run")

   // A coefficient that is not the last of its request is followed by another.
   `TRS_ASSERT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_run_end |=> rsp_valid, "run ended without its last coefficient")

   // A new run of responses starts only right after a request was taken.
   `TRS_ASSERT(a_rsp_has_cause, clock, reset, rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready), "response without a request")

endmodule

bind ternary_rejection_sampler trs_checker u_trs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_coefficient (rsp_coefficient),
   .rsp_run_end     (rsp_run_end),
   .rsp_poly_end    (rsp_poly_end)
);
